// ===== src/adir_pkg.sv =====
// Shared types, register indices and constants of the adaptive DPCM reconstruction block.
package adir_pkg;

  typedef logic signed [15:0] pixel_t;

  // Register indices as seen on paddr[3:2].
  localparam logic [1:0] REG_SKIP  = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_LINES = 2'd2;

  // Gradients at or above this value never select a predictor.
  localparam logic [16:0] GRAD_LIMIT = 17'd1000;

  // Per-pixel position information that the predictor needs.
  typedef struct packed {
    logic skip;    // bypass: the pixel is the residual
    logic c_gt0;   // a left neighbour exists
    logic c_gt1;   // two left neighbours exist
    logic r_gt1;   // two rows above exist
    logic ur_ok;   // two up-right neighbours exist
  } pred_ctl_t;

  // Row buffer that holds the row directly above the current one.
  function automatic logic [1:0] up1_of(input logic [1:0] rot);
    logic [1:0] idx;
    case (rot)
      2'd0:    idx = 2'd2;
      2'd1:    idx = 2'd0;
      default: idx = 2'd1;
    endcase
    return idx;
  endfunction

  // Row buffer that holds the row two above the current one.
  function automatic logic [1:0] up2_of(input logic [1:0] rot);
    logic [1:0] idx;
    case (rot)
      2'd0:    idx = 2'd1;
      2'd1:    idx = 2'd2;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

// ===== src/adaptive_dpcm_image_reconstruct.sv =====
// Top level of the adaptive DPCM image reconstruction block.
// The block takes one signed 16-bit prediction residual per request, in raster order, and
// returns one reconstructed 16-bit pixel per request together with a flag on the last
// pixel of the image. It sustains one request per clock cycle while in_stall_o is low: an
// accepted request is registered into the compute stage, where its pixel is computed, and
// the result is then registered into the output register behind out_valid_o. That
// rate is set by the three row buffers, each a RAM with one write port and two registered
// read ports: every request reads the two rows above at its own column and one or two
// columns to the right, while the pixel of the previous request is written back. The
// remaining neighbours (left pixels and the earlier columns of the rows above) are held in
// registers as the row streams past. The row buffers are not cleared after reset; a pixel
// from a row is only used once that row has been written in the current image. The
// configuration registers (bypass, line width, lines per image) must only be written while
// no request is in flight; a write of either geometry register restarts the image.
module adaptive_dpcm_image_reconstruct import adir_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Residual input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] residual_i,
  // Pixel output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_o,
  output logic        frame_end_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  // Line width after reset, limited to what the row buffers hold.
  localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam logic [AW-1:0] WM1_RST = AW'(WIDTH_RST - 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(MAX_WIDTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic          skip_q;
  logic [10:0]   line_width_q;
  logic [15:0]   frame_lines_q;
  logic [AW-1:0] wm1_q;          // effective line width minus one
  logic [AW-1:0] wm1_d;
  logic [15:0]   hm1;            // effective lines per image minus one
  logic          cfg_wr;
  logic          geom_wr;

  assign cfg_wr  = psel && penable && pwrite;
  assign geom_wr = cfg_wr && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_LINES));
  assign pready  = 1'b1;

  // A width of zero behaves as one, and a width above the buffer depth as the depth.
  always_comb begin
    if (pwdata[10:0] == 11'd0) begin
      wm1_d = '0;
    end else if ({21'b0, pwdata[10:0]} > 32'(MAX_WIDTH)) begin
      wm1_d = AW'(MAX_WIDTH - 1);
    end else begin
      wm1_d = AW'({21'b0, pwdata[10:0]} - 32'd1);
    end
  end

  // Zero lines per image behaves as one.
  assign hm1 = (frame_lines_q == 16'd0) ? 16'd0 : frame_lines_q - 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q        <= 1'b0;
      line_width_q  <= 11'd1024;
      frame_lines_q <= 16'd1;
      wm1_q         <= WM1_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SKIP: begin
          skip_q <= pwdata[0];
        end
        REG_WIDTH: begin
          line_width_q <= pwdata[10:0];
          wm1_q        <= wm1_d;
        end
        REG_LINES: begin
          frame_lines_q <= pwdata[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SKIP:  prdata = {31'b0, skip_q};
      REG_WIDTH: prdata = {21'b0, line_width_q};
      REG_LINES: prdata = {16'b0, frame_lines_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake and position counters
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_adv;
  logic in_acc;
  logic out_valid_q;

  // The compute stage moves on whenever the output register is empty or being emptied.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Position of the next request to be accepted.
  logic [AW-1:0] col_q;
  logic [15:0]   row_q;
  logic [1:0]    rot_q;          // row buffer that takes the current row
  logic          col_end;
  logic          row_end;

  assign col_end = (col_q == wm1_q);
  assign row_end = (row_q == hm1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rot_q <= '0;
    end else if (geom_wr) begin
      col_q <= '0;
      row_q <= '0;
      rot_q <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? 16'd0 : row_q + 16'd1;
        rot_q <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // Neighbour flags of the request being accepted.
  pred_ctl_t acc_ctl;
  logic [AW:0] col_p1;
  logic [AW:0] col_p2;

  assign col_p1 = {1'b0, col_q} + (AW+1)'(1);
  assign col_p2 = {1'b0, col_q} + (AW+1)'(2);

  always_comb begin
    acc_ctl.skip  = skip_q;
    acc_ctl.c_gt0 = (col_q != '0);
    acc_ctl.c_gt1 = (col_q > AW'(1));
    acc_ctl.r_gt1 = (row_q > 16'd1);
    acc_ctl.ur_ok = (col_p2 <= {1'b0, wm1_q});
  end

  // ---------------------------------------------------------------------------
  // Row buffers
  // ---------------------------------------------------------------------------
  // The row above is read at the column and one to the right, the row two above at the
  // column and two to the right. Addresses past the buffer end wrap; such reads are
  // never used.
  logic [AW-1:0] addr_p1;
  logic [AW-1:0] addr_p2;
  logic [1:0]    acc_up1;

  assign addr_p1 = AW'((col_p1 >= DEPTH_EXT) ? col_p1 - DEPTH_EXT : col_p1);
  assign addr_p2 = AW'((col_p2 >= DEPTH_EXT) ? col_p2 - DEPTH_EXT : col_p2);
  assign acc_up1 = up1_of(rot_q);

  // Compute stage registers.
  pixel_t        s1_res_q;
  logic [AW-1:0] s1_col_q;
  logic [1:0]    s1_rot_q;
  pred_ctl_t     s1_ctl_q;
  logic          s1_last_q;
  pixel_t        pixel_new;

  pixel_t ram_a [3];
  pixel_t ram_b [3];

  for (genvar k = 0; k < 3; k++) begin : g_row
    adir_ram #(
      .WIDTH(16),
      .DEPTH(MAX_WIDTH)
    ) u_row_ram (
      .clk_i     (clk_i),
      .we_i      (s1_adv && (s1_rot_q == 2'(k))),
      .waddr_i   (s1_col_q),
      .wdata_i   (pixel_new),
      .re_i      (in_acc),
      .raddr_a_i (col_q),
      .raddr_b_i ((acc_up1 == 2'(k)) ? addr_p1 : addr_p2),
      .rdata_a_o (ram_a[k]),
      .rdata_b_o (ram_b[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q  <= pixel_t'(residual_i);
      s1_col_q  <= col_q;
      s1_rot_q  <= rot_q;
      s1_ctl_q  <= acc_ctl;
      s1_last_q <= col_end && row_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Neighbour window
  // ---------------------------------------------------------------------------
  // The RAM read data belongs to the request in the compute stage. As each request
  // leaves, its reads at its own column slide into registers so that the next
  // requests see the earlier columns of the rows above, and its pixel becomes the
  // left neighbour.
  pixel_t up1_c;
  pixel_t up1_p1;
  pixel_t up2_c;
  pixel_t up2_p2;
  pixel_t left1_q;
  pixel_t left2_q;
  pixel_t up1_m1_q;
  pixel_t up2_m1_q;
  pixel_t up2_m2_q;

  assign up1_c  = ram_a[up1_of(s1_rot_q)];
  assign up1_p1 = ram_b[up1_of(s1_rot_q)];
  assign up2_c  = ram_a[up2_of(s1_rot_q)];
  assign up2_p2 = ram_b[up2_of(s1_rot_q)];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left1_q  <= pixel_new;
      left2_q  <= left1_q;
      up1_m1_q <= up1_c;
      up2_m1_q <= up2_c;
      up2_m2_q <= up2_m1_q;
    end
  end

  adir_pred u_pred (
    .ctl_i      (s1_ctl_q),
    .residual_i (s1_res_q),
    .left1_i    (left1_q),
    .left2_i    (left2_q),
    .up1_m1_i   (up1_m1_q),
    .up1_c_i    (up1_c),
    .up1_p1_i   (up1_p1),
    .up2_m2_i   (up2_m2_q),
    .up2_c_i    (up2_c),
    .up2_p2_i   (up2_p2),
    .pixel_o    (pixel_new)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  pixel_t pixel_q;
  logic   frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_q     <= pixel_new;
      frame_end_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign frame_end_o = frame_end_q;

endmodule

// ===== src/adir_ram.sv =====
// Generic single-write, dual-read RAM with registered, write-through read ports.
module adir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // A read of the address being written returns the new data.
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/adir_pred.sv =====
// Directional gradient measurement, predictor choice and pixel reconstruction.
module adir_pred import adir_pkg::*; (
  input  pred_ctl_t ctl_i,
  input  pixel_t    residual_i,
  input  pixel_t    left1_i,
  input  pixel_t    left2_i,
  input  pixel_t    up1_m1_i,
  input  pixel_t    up1_c_i,
  input  pixel_t    up1_p1_i,
  input  pixel_t    up2_m2_i,
  input  pixel_t    up2_c_i,
  input  pixel_t    up2_p2_i,
  output pixel_t    pixel_o
);

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_LEFT,
    SEL_UP,
    SEL_UPLEFT,
    SEL_UPRIGHT
  } sel_e;

  function automatic logic [16:0] abs_diff(input pixel_t a, input pixel_t b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    return d[16] ? 17'(-d) : 17'(d);
  endfunction

  logic [16:0] grad_left;
  logic [16:0] grad_up;
  logic [16:0] grad_ul;
  logic [16:0] grad_ur;
  logic [16:0] dmin;
  sel_e        sel;
  pixel_t      pred;

  assign grad_left = abs_diff(left1_i, left2_i);
  assign grad_up   = abs_diff(up1_c_i, up2_c_i);
  assign grad_ul   = abs_diff(up1_m1_i, up2_m2_i);
  assign grad_ur   = abs_diff(up1_p1_i, up2_p2_i);

  // Directions are tried in a fixed order; a later one wins only if strictly smaller.
  always_comb begin
    dmin = GRAD_LIMIT;
    sel  = SEL_NONE;
    if (ctl_i.c_gt1 && (grad_left < dmin)) begin
      dmin = grad_left;
      sel  = SEL_LEFT;
    end
    if (ctl_i.r_gt1 && (grad_up < dmin)) begin
      dmin = grad_up;
      sel  = SEL_UP;
    end
    if (ctl_i.r_gt1 && ctl_i.c_gt1 && (grad_ul < dmin)) begin
      dmin = grad_ul;
      sel  = SEL_UPLEFT;
    end
    if (ctl_i.r_gt1 && ctl_i.ur_ok && (grad_ur < dmin)) begin
      dmin = grad_ur;
      sel  = SEL_UPRIGHT;
    end
  end

  always_comb begin
    case (sel)
      SEL_LEFT:    pred = left1_i;
      SEL_UP:      pred = up1_c_i;
      SEL_UPLEFT:  pred = up1_m1_i;
      SEL_UPRIGHT: pred = up1_p1_i;
      default:     pred = ctl_i.c_gt0 ? left1_i : '0;
    endcase
  end

  assign pixel_o = ctl_i.skip ? residual_i : pixel_t'(residual_i + pred);

endmodule

// ===== src/adir_chk.sv =====
// Port-level checker for the adaptive DPCM reconstruction block, bound to the top level.
module adir_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] pixel_o,
  input logic        frame_end_o
);

  // The input is only held back by a result that is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output is free");

  // An accepted request is followed by a result on offer.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)
    else $error("no result offered after an accepted request");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(pixel_o) && $stable(frame_end_o)))
    else $error("stalled result changed or was withdrawn");

endmodule

bind adaptive_dpcm_image_reconstruct adir_chk u_adir_chk (.*);
